// ----- design/iall_pkg.sv -----
`default_nettype none

package iall_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int MODE_W = 2;
  localparam int POS_W  = 5;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int IDX_W  = 4;
  localparam int LEN_W  = 5;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_UPDATE = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_FIND   = 2'd3
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_DOWN,
    S_FIND,
    S_TAIL,
    S_PUT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  result_index;
    logic [LEN_W-1:0]  list_length;
  } res_t;

endpackage

`default_nettype wire

// ----- design/iall_req_if.sv -----
`default_nettype none

interface iall_req_if;
  logic                              valid;
  logic                              ready;
  logic [iall_pkg::MODE_W-1:0]       mode;
  logic [iall_pkg::POS_W-1:0]        position;
  logic signed [iall_pkg::VAL_W-1:0] value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink (input valid, input mode, input position, input value, output ready);
endinterface

`default_nettype wire

// ----- design/iall_rsp_if.sv -----
`default_nettype none

interface iall_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [iall_pkg::STAT_W-1:0] status;
  logic [iall_pkg::IDX_W-1:0]  result_index;
  logic [iall_pkg::LEN_W-1:0]  list_length;

  modport source (output valid, output status, output result_index, output list_length,
                  input ready);
  modport sink (input valid, input status, input result_index, input list_length,
                output ready);
endinterface

`default_nettype wire

// ----- design/iall_ram.sv -----
`default_nettype none

module iall_ram #(
  parameter int DEPTH = iall_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                              clk_i,
  input  wire logic                              we_i,
  input  wire logic [AW-1:0]                     waddr_i,
  input  wire logic signed [iall_pkg::VAL_W-1:0] wdata_i,
  input  wire logic                              re_i,
  input  wire logic [AW-1:0]                     raddr_i,
  output logic signed [iall_pkg::VAL_W-1:0]      rdata_o
);
  import iall_pkg::*;

  logic signed [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- design/iall_seq.sv -----
`default_nettype none

module iall_seq #(
  parameter int DEPTH = iall_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [iall_pkg::CAP_W-1:0]        cap_i,
  input  wire logic                              req_valid_i,
  output logic                                   req_ready_o,
  input  wire iall_pkg::req_t                    req_i,
  output logic                                   done_o,
  output iall_pkg::res_t                         res_o,
  input  wire logic                              res_ready_i,
  output logic                                   ram_we_o,
  output logic [AW-1:0]                          ram_waddr_o,
  output logic signed [iall_pkg::VAL_W-1:0]      ram_wdata_o,
  output logic                                   ram_re_o,
  output logic [AW-1:0]                          ram_raddr_o,
  input  wire logic signed [iall_pkg::VAL_W-1:0] ram_rdata_i
);
  import iall_pkg::*;

  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  state_e                  state_q, state_d;
  mode_e                   op_q, op_d;
  status_e                 status_q, status_d;
  logic [CW-1:0]           count_q, count_d;
  logic [AW-1:0]           ptr_q, ptr_d;
  logic [AW-1:0]           last_q, last_d;
  logic [AW-1:0]           pos_q, pos_d;
  logic [AW-1:0]           where_q, where_d;
  logic [AW-1:0]           pend_addr_q, pend_addr_d;
  logic                    pend_q, pend_d;
  logic                    hit_q, hit_d;
  logic signed [VAL_W-1:0] word_q, word_d;

  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic            full;

  assign pos_ext = CMPW'(req_i.position);
  assign cnt_ext = CMPW'(count_q);
  // usable capacity is the smaller of the register and the store
  assign full = (cnt_ext >= CMPW'(cap_i)) || (count_q == CW'(DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= MODE_INSERT;
      status_q <= ST_OK;
      count_q  <= '0;
      pend_q   <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      status_q <= status_d;
      count_q  <= count_d;
      pend_q   <= pend_d;
      hit_q    <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q       <= ptr_d;
    last_q      <= last_d;
    pos_q       <= pos_d;
    where_q     <= where_d;
    pend_addr_q <= pend_addr_d;
    word_q      <= word_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    status_d    = status_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    last_d      = last_q;
    pos_d       = pos_q;
    where_d     = where_q;
    pend_addr_d = pend_addr_q;
    pend_d      = 1'b0;
    hit_d       = hit_q;
    word_d      = word_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = pend_addr_q;
    ram_wdata_o = ram_rdata_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = ptr_q;

    // word read last cycle: move it or compare it against the key
    if (pend_q) begin
      if (op_q == MODE_FIND) begin
        if (ram_rdata_i == word_q) begin
          hit_d   = 1'b1;
          where_d = pend_addr_q;
        end
      end else begin
        ram_we_o = 1'b1;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_d     = mode_e'(req_i.mode);
          word_d   = req_i.value;
          pos_d    = AW'(req_i.position);
          where_d  = '0;
          hit_d    = 1'b0;
          status_d = ST_OK;
          state_d  = S_DONE;
          case (mode_e'(req_i.mode))
            MODE_INSERT: begin
              if (full) begin
                status_d = ST_FULL;
              end else if (pos_ext > cnt_ext) begin
                status_d = ST_RANGE;
              end else begin
                count_d = count_q + CW'(1);
                where_d = AW'(req_i.position);
                if (pos_ext < cnt_ext) begin
                  ptr_d   = AW'(count_q - CW'(1));
                  state_d = S_UP;
                end else begin
                  state_d = S_PUT;
                end
              end
            end
            MODE_UPDATE: begin
              if (pos_ext >= cnt_ext) begin
                status_d = ST_RANGE;
              end else begin
                state_d = S_PUT;
              end
            end
            MODE_DELETE: begin
              if (pos_ext >= cnt_ext) begin
                status_d = ST_RANGE;
              end else begin
                count_d = count_q - CW'(1);
                if ((pos_ext + CMPW'(1)) < cnt_ext) begin
                  ptr_d   = AW'(req_i.position) + AW'(1);
                  last_d  = AW'(count_q - CW'(1));
                  state_d = S_DOWN;
                end
              end
            end
            MODE_FIND: begin
              if (count_q != '0) begin
                ptr_d   = '0;
                last_d  = AW'(count_q - CW'(1));
                state_d = S_FIND;
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end
      S_UP: begin
        ram_re_o    = 1'b1;
        pend_d      = 1'b1;
        pend_addr_d = ptr_q + AW'(1);
        if (ptr_q == pos_q) begin
          state_d = S_TAIL;
        end else begin
          ptr_d = ptr_q - AW'(1);
        end
      end
      S_DOWN: begin
        ram_re_o    = 1'b1;
        pend_d      = 1'b1;
        pend_addr_d = ptr_q - AW'(1);
        if (ptr_q == last_q) begin
          state_d = S_TAIL;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      S_FIND: begin
        ram_re_o    = 1'b1;
        pend_d      = 1'b1;
        pend_addr_d = ptr_q;
        if (ptr_q == last_q) begin
          state_d = S_TAIL;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      S_TAIL: begin
        state_d = (op_q == MODE_INSERT) ? S_PUT : S_DONE;
      end
      S_PUT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = pos_q;
        ram_wdata_o = word_q;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign done_o      = (state_q == S_DONE);

  always_comb begin
    res_o.status = status_q;
    if ((op_q == MODE_FIND) && !hit_q) begin
      res_o.status = ST_MISSING;
    end
    res_o.result_index = (res_o.status == ST_OK) ? IDX_W'(where_q) : '0;
    res_o.list_length  = LEN_W'(count_q);
  end

endmodule

`default_nettype wire

// ----- design/indexed_array_list_core.sv -----
`default_nettype none

// channel   dir  handshake      word contents
// req_i     in   valid/ready    mode, position, value
// rsp_o     out  valid/ready    status, result_index, list_length
// cfg       in   cfg_we_i       capacity_limit (cfg_wdata_i), no read-back
//
// one request at a time; the list store has a single read and a single write port
// per request: update writes the word; insert moves the entries from the position up
// one slot, top entry first, then writes the word; delete moves those above it down;
// find reads and compares every entry; rejected requests go straight to the result
// reset clears the length and the capacity (to 16); the store itself is not cleared
// a finished word waits in the output register while the next request is taken;
// that request holds in its final state until the output register is free

module indexed_array_list_core #(
  parameter int DEPTH = iall_pkg::DEPTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [iall_pkg::CAP_W-1:0] cfg_wdata_i,
  iall_req_if.sink                        req_i,
  iall_rsp_if.source                      rsp_o
);
  import iall_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // capacity register
  logic [CAP_W-1:0] cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // request word into the sequencer
  req_t req;
  logic req_ready;

  assign req.mode     = req_i.mode;
  assign req.position = req_i.position;
  assign req.value    = req_i.value;
  assign req_i.ready  = req_ready;

  // sequencer to output register
  logic done;
  res_t res;
  logic slot_free;

  // ram port
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic signed [VAL_W-1:0] ram_wdata;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  logic signed [VAL_W-1:0] ram_rdata;

  iall_seq #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_i       (cap_q),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .done_o      (done),
    .res_o       (res),
    .res_ready_i (slot_free),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  iall_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register: decouples the result word from the next request
  logic out_valid_q, out_valid_d;
  res_t out_res_q;

  assign slot_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    // a finished word loads only when the slot is free
    if (done && slot_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done && slot_free) begin
      out_res_q <= res;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_res_q.status;
  assign rsp_o.result_index = out_res_q.result_index;
  assign rsp_o.list_length  = out_res_q.list_length;

endmodule

`default_nettype wire
